// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clock
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset only
`define WSG_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define WSG_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/wsg_pkg.sv =====
// ----------------------------------------------------------------------------
// wsg_pkg
// shared types and constants of the wavetable sound generator
// ----------------------------------------------------------------------------
package wsg_pkg;

   localparam int NUM_CH       = 6;
   localparam int WAVE_DEPTH   = 32;
   localparam int WAVE_ENTRIES = NUM_CH * WAVE_DEPTH;
   localparam int WAVE_AW      = $clog2(WAVE_ENTRIES);
   localparam int CH_W         = 3;
   localparam int RATE_W       = 17;
   localparam int PHASE_W      = 21;
   localparam int NPHASE_W     = 32;
   localparam int LFSR_W       = 18;
   localparam int CSR_AW       = 4;

   // register index codes
   localparam logic [1:0] CSR_MASTER_VOLUME = 2'd0;
   localparam logic [1:0] CSR_CHANNEL_MASK  = 2'd1;
   localparam logic [1:0] CSR_SAMPLE_RATE   = 2'd2;

   localparam logic [7:0]        MASTER_VOLUME_RST = 8'd255;
   localparam logic [NUM_CH-1:0] CHANNEL_MASK_RST  = 6'd63;
   localparam logic [RATE_W-1:0] SAMPLE_RATE_RST   = 17'd22050;

   // field select codes
   localparam logic [2:0] FS_CONTROL   = 3'd0;
   localparam logic [2:0] FS_BALANCE   = 3'd1;
   localparam logic [2:0] FS_FREQ_LOW  = 3'd2;
   localparam logic [2:0] FS_FREQ_HIGH = 3'd3;
   localparam logic [2:0] FS_NOISE     = 3'd4;
   localparam logic [2:0] FS_DDA       = 3'd5;
   localparam logic [2:0] FS_WAVE      = 3'd6;

   localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
   localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

   typedef enum logic [2:0] {
      SRC_OFF,
      SRC_DDA,
      SRC_NOISE,
      SRC_WAVE,
      SRC_MUTE
   } src_type;

   typedef enum logic [1:0] {
      DSEL_CLK,
      DSEL_NOISE,
      DSEL_WAVE
   } dsel_type;

   typedef struct packed {
      logic            mode;
      logic [2:0]      channel;
      logic [2:0]      field_select;
      logic [4:0]      wave_slot;
      logic [7:0]      write_value;
   } wsg_item_type;

   typedef struct packed {
      logic [7:0]        master_volume;
      logic [NUM_CH-1:0] channel_mask;
      logic [RATE_W-1:0] sample_rate;
   } wsg_cfg_type;

   typedef struct packed {
      logic            write;
      logic            tick_start;
      logic            div_start;
      dsel_type        div_sel;
      logic            cap_q1;
      logic            cap_ninc;
      logic            ch_load;
      logic            wave_adv;
      logic            noise_add;
      logic            noise_step;
      logic            mul;
      logic            acc;
      logic            load_out;
      logic [CH_W-1:0] ch;
   } wsg_cmd_type;

   typedef struct packed {
      logic    div_done;
      src_type src;
      logic    noise_more;
   } wsg_stat_type;

   // 5-bit level to signed sample, zero is skipped
   function automatic logic signed [5:0] centered(input logic [4:0] v);
      return signed'({1'b0, v}) - 6'sd16 + signed'({5'b0, v[4]});
   endfunction

endpackage

// ===== hw/rtl/wsg_if.sv =====
// ----------------------------------------------------------------------------
// wsg_if
// valid/ready channels for request words and sample words
// ----------------------------------------------------------------------------
interface wsg_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [2:0] channel;
   logic [2:0] field_select;
   logic [4:0] wave_slot;
   logic [7:0] write_value;

   modport source (output valid, mode, channel, field_select, wave_slot, write_value,
                   input ready);
   modport sink (input valid, mode, channel, field_select, wave_slot, write_value,
                 output ready);
endinterface

interface wsg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] left_sample;
   logic signed [15:0] right_sample;

   modport source (output valid, left_sample, right_sample, input ready);
   modport sink (input valid, left_sample, right_sample, output ready);
endinterface

// ===== hw/rtl/wsg_div.sv =====
// ----------------------------------------------------------------------------
// wsg_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wsg_div
   import wsg_pkg::*;
#(
   parameter int DVD_W = 38
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DVD_W-1:0]  dividend,
   input  logic [RATE_W-1:0] divisor,
   output logic              done,
   output logic [DVD_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(DVD_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0]  shf_ff, shf_in;
   logic [RATE_W-1:0] dvs_ff, dvs_in;
   logic [RATE_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      shf_in  = shf_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, shf_ff[DVD_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         shf_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = RATE_W'(trial - {1'b0, dvs_ff});
            shf_in = {shf_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[RATE_W-1:0];
            shf_in = {shf_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = shf_ff;

endmodule

// ===== hw/rtl/wsg_dp.sv =====
// ----------------------------------------------------------------------------
// wsg_dp
// channel state, wave memory, noise lfsrs, step divider and stereo mixer
// ----------------------------------------------------------------------------
module wsg_dp
   import wsg_pkg::*;
#(
   parameter int PSG_CLOCK_HZ = 3579545
) (
   input  logic               clock,
   input  logic               reset,
   input  wsg_cmd_type        cmd,
   output wsg_stat_type       stat,
   input  wsg_item_type       item,
   input  wsg_cfg_type        cfg,
   output logic signed [15:0] left_sample,
   output logic signed [15:0] right_sample
);

   localparam int CLK_W = $clog2(PSG_CLOCK_HZ + 1);
   localparam int DVD_W = CLK_W + 16;
   localparam logic [CLK_W-1:0] CLK_VAL = CLK_W'(PSG_CLOCK_HZ);

   // per-channel registers
   logic [7:0]         ctl_ff   [NUM_CH];
   logic [7:0]         bal_ff   [NUM_CH];
   logic [11:0]        per_ff   [NUM_CH];
   logic [7:0]         nctl_ff  [NUM_CH];
   logic [4:0]         dda_ff   [NUM_CH];
   logic [PHASE_W-1:0] phase_ff [NUM_CH];
   logic [4:0]         ptr_ff   [NUM_CH];

   // noise generators of the last two channels
   logic [NPHASE_W-1:0] nphase_ff [2];
   logic [LFSR_W-1:0]   nshift_ff [2];
   logic signed [4:0]   nout_ff   [2];

   // wave memory
   logic [4:0]              wave_mem [WAVE_ENTRIES];
   logic [WAVE_ENTRIES-1:0] wave_vld_ff;
   logic [4:0]              rd_data_ff;
   logic                    rd_vld_ff;
   logic [WAVE_AW-1:0]      wr_addr, rd_addr;
   logic                    wr_ok, wave_wr;

   logic [CLK_W-1:0]    q1_ff;
   logic [NPHASE_W-1:0] ninc_ff;
   logic [4:0]          lv_ff, rv_ff;
   logic signed [11:0]  prod_l_ff, prod_r_ff;
   logic signed [15:0]  acc_l_ff, acc_r_ff;
   logic signed [15:0]  out_l_ff, out_r_ff;

   // divider hookup
   logic                div_done;
   logic [DVD_W-1:0]    div_quot, div_dvd;
   logic [RATE_W-1:0]   div_dvs, rate_eff;

   // selected channel view
   logic [CH_W-1:0]     c;
   logic                n;
   logic [7:0]          ctl_s, bal_s, nctl_s;
   logic [11:0]         per_s;
   logic [4:0]          f;
   logic [10:0]         np;
   logic [26:0]         npf;
   logic [7:0]          pan9_l, pan9_r;
   logic [12:0]         vol_l, vol_r;
   logic signed [5:0]   s;
   logic [PHASE_W-1:0]  phase_new;
   logic signed [16:0]  term_l, term_r;
   logic signed [17:0]  sum_l, sum_r;
   logic signed [15:0]  sat_l, sat_r;
   logic [LFSR_W-1:0]   v;
   logic                fb;
   src_type             src;

   assign c      = cmd.ch;
   assign n      = cmd.ch[0];
   assign ctl_s  = ctl_ff[c];
   assign bal_s  = bal_ff[c];
   assign nctl_s = nctl_ff[c];
   assign per_s  = per_ff[c];

   always_comb begin
      if (!ctl_s[7])
         src = SRC_OFF;
      else if (ctl_s[6])
         src = SRC_DDA;
      else if ((c == CH_W'(4) || c == CH_W'(5)) && nctl_s[7])
         src = SRC_NOISE;
      else if (per_s != '0)
         src = SRC_WAVE;
      else
         src = SRC_MUTE;
   end

   // lfsr period in 11.16
   assign f   = nctl_s[4:0];
   assign np  = (f == 5'h1F) ? 11'd32 : {~f, 6'b0};
   assign npf = {np, 16'b0};

   assign stat.div_done   = div_done;
   assign stat.src        = src;
   assign stat.noise_more = nphase_ff[n] >= NPHASE_W'(npf);

   assign rate_eff = (cfg.sample_rate == '0) ? RATE_W'(1) : cfg.sample_rate;

   always_comb begin
      case (cmd.div_sel)
         DSEL_CLK: begin
            div_dvd = DVD_W'(CLK_VAL);
            div_dvs = rate_eff;
         end
         DSEL_NOISE: begin
            div_dvd = {CLK_VAL, 16'b0};
            div_dvs = rate_eff;
         end
         DSEL_WAVE: begin
            div_dvd = {q1_ff, 16'b0};
            div_dvs = RATE_W'(per_s);
         end
         default: begin
            div_dvd = '0;
            div_dvs = RATE_W'(1);
         end
      endcase
   end

   wsg_div #(.DVD_W(DVD_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quot)
   );

   // channel volume per side
   assign pan9_l = {1'b0, bal_s[7:4], 3'b0} + 8'(bal_s[7:4]);
   assign pan9_r = {1'b0, bal_s[3:0], 3'b0} + 8'(bal_s[3:0]);
   assign vol_l  = 13'(pan9_l) * 13'(ctl_s[4:0]);
   assign vol_r  = 13'(pan9_r) * 13'(ctl_s[4:0]);

   always_comb begin
      case (src)
         SRC_DDA:   s = centered(dda_ff[c]);
         SRC_NOISE: s = 6'(nout_ff[n]);
         SRC_WAVE:  s = rd_vld_ff ? centered(rd_data_ff) : centered(5'd0);
         default:   s = '0;
      endcase
   end

   assign phase_new = phase_ff[c] + div_quot[PHASE_W-1:0];

   assign v  = nshift_ff[n];
   assign fb = v[0] ^ v[1] ^ v[11] ^ v[12] ^ v[17];

   assign term_l = prod_l_ff * signed'({1'b0, cfg.master_volume[7:4]});
   assign term_r = prod_r_ff * signed'({1'b0, cfg.master_volume[3:0]});
   assign sum_l  = 18'(acc_l_ff) + 18'(term_l);
   assign sum_r  = 18'(acc_r_ff) + 18'(term_r);

   always_comb begin
      if (sum_l > SAMPLE_MAX)
         sat_l = SAMPLE_MAX[15:0];
      else if (sum_l < SAMPLE_MIN)
         sat_l = SAMPLE_MIN[15:0];
      else
         sat_l = sum_l[15:0];
      if (sum_r > SAMPLE_MAX)
         sat_r = SAMPLE_MAX[15:0];
      else if (sum_r < SAMPLE_MIN)
         sat_r = SAMPLE_MIN[15:0];
      else
         sat_r = sum_r[15:0];
   end

   assign wr_ok   = cmd.write && (item.channel < CH_W'(NUM_CH));
   assign wave_wr = wr_ok && (item.field_select == FS_WAVE);
   assign wr_addr = {item.channel, item.wave_slot};
   assign rd_addr = {c, ptr_ff[c]};

   // channel and noise state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CH; i++) begin
            ctl_ff[i]   <= '0;
            bal_ff[i]   <= '0;
            per_ff[i]   <= '0;
            nctl_ff[i]  <= '0;
            dda_ff[i]   <= '0;
            phase_ff[i] <= '0;
            ptr_ff[i]   <= '0;
         end
         for (int k = 0; k < 2; k++) begin
            nphase_ff[k] <= '0;
            nshift_ff[k] <= LFSR_W'(1);
            nout_ff[k]   <= '0;
         end
         wave_vld_ff <= '0;
      end else begin
         if (wr_ok) begin
            case (item.field_select)
               FS_CONTROL:   ctl_ff[item.channel]        <= item.write_value;
               FS_BALANCE:   bal_ff[item.channel]        <= item.write_value;
               FS_FREQ_LOW:  per_ff[item.channel][7:0]   <= item.write_value;
               FS_FREQ_HIGH: per_ff[item.channel][11:8]  <= item.write_value[3:0];
               FS_NOISE:     nctl_ff[item.channel]       <= item.write_value;
               FS_DDA:       dda_ff[item.channel]        <= item.write_value[4:0];
               FS_WAVE:      wave_vld_ff[wr_addr]        <= 1'b1;
               default: ;
            endcase
         end
         if (cmd.mul && src == SRC_OFF)
            phase_ff[c] <= '0;
         if (cmd.wave_adv) begin
            phase_ff[c] <= phase_new;
            ptr_ff[c]   <= phase_new[PHASE_W-1:16];
         end
         if (cmd.noise_add)
            nphase_ff[n] <= nphase_ff[n] + ninc_ff;
         if (cmd.noise_step) begin
            nphase_ff[n] <= nphase_ff[n] - NPHASE_W'(npf);
            nout_ff[n]   <= v[0] ? 5'sd15 : -5'sd16;
            nshift_ff[n] <= {fb, v[LFSR_W-1:1]};
         end
      end
   end

   // wave memory write and registered read
   always_ff @(posedge clock) begin
      if (wave_wr)
         wave_mem[wr_addr] <= item.write_value[4:0];
      if (cmd.ch_load)
         rd_data_ff <= wave_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ch_load) begin
         rd_vld_ff <= wave_vld_ff[rd_addr];
         lv_ff     <= vol_l[12:8];
         rv_ff     <= vol_r[12:8];
      end
      if (cmd.cap_q1)
         q1_ff <= div_quot[CLK_W-1:0];
      if (cmd.cap_ninc)
         ninc_ff <= div_quot[NPHASE_W-1:0];
      if (cmd.mul) begin
         prod_l_ff <= 12'(s) * signed'({7'b0, lv_ff});
         prod_r_ff <= 12'(s) * signed'({7'b0, rv_ff});
      end
      if (cmd.tick_start) begin
         acc_l_ff <= '0;
         acc_r_ff <= '0;
      end else if (cmd.acc && cfg.channel_mask[c]) begin
         acc_l_ff <= sat_l;
         acc_r_ff <= sat_r;
      end
      if (cmd.load_out) begin
         out_l_ff <= acc_l_ff;
         out_r_ff <= acc_r_ff;
      end
   end

   assign left_sample  = out_l_ff;
   assign right_sample = out_r_ff;

endmodule

// ===== hw/rtl/wsg_ctrl.sv =====
// ----------------------------------------------------------------------------
// wsg_ctrl
// sequencer: field writes, step divisions, per-channel walk, sample hand-off
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wsg_ctrl
   import wsg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_mode,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  wsg_stat_type stat,
   output wsg_cmd_type  cmd
);

   typedef enum logic [9:0] {
      ST_IDLE       = 10'b0000000001,
      ST_DIV_CLK    = 10'b0000000010,
      ST_DIV_NOISE  = 10'b0000000100,
      ST_CH_START   = 10'b0000001000,
      ST_CH_DIV     = 10'b0000010000,
      ST_NOISE_ADD  = 10'b0000100000,
      ST_NOISE_STEP = 10'b0001000000,
      ST_CH_MUL     = 10'b0010000000,
      ST_CH_ACC     = 10'b0100000000,
      ST_OUT        = 10'b1000000000
   } state_type;

   state_type       state_ff, state_in;
   logic [CH_W-1:0] ch_ff, ch_in;
   logic            rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      ch_in     = ch_ff;
      cmd       = '0;
      cmd.ch    = ch_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_mode) begin
                  cmd.write = 1'b1;
               end else begin
                  cmd.tick_start = 1'b1;
                  cmd.div_start  = 1'b1;
                  cmd.div_sel    = DSEL_CLK;
                  ch_in          = '0;
                  state_in       = ST_DIV_CLK;
               end
            end
         end
         ST_DIV_CLK: begin
            if (stat.div_done) begin
               cmd.cap_q1    = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DSEL_NOISE;
               state_in      = ST_DIV_NOISE;
            end
         end
         ST_DIV_NOISE: begin
            if (stat.div_done) begin
               cmd.cap_ninc = 1'b1;
               state_in     = ST_CH_START;
            end
         end
         ST_CH_START: begin
            cmd.ch_load = 1'b1;
            case (stat.src)
               SRC_WAVE: begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DSEL_WAVE;
                  state_in      = ST_CH_DIV;
               end
               SRC_NOISE: state_in = ST_NOISE_ADD;
               default:   state_in = ST_CH_MUL;
            endcase
         end
         ST_CH_DIV: begin
            if (stat.div_done) begin
               cmd.wave_adv = 1'b1;
               state_in     = ST_CH_MUL;
            end
         end
         ST_NOISE_ADD: begin
            cmd.noise_add = 1'b1;
            state_in      = ST_NOISE_STEP;
         end
         ST_NOISE_STEP: begin
            if (stat.noise_more)
               cmd.noise_step = 1'b1;
            else
               state_in = ST_CH_MUL;
         end
         ST_CH_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_CH_ACC;
         end
         ST_CH_ACC: begin
            cmd.acc = 1'b1;
            if (ch_ff == CH_W'(NUM_CH - 1)) begin
               state_in = ST_OUT;
            end else begin
               ch_in    = ch_ff + 1'b1;
               state_in = ST_CH_START;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `WSG_ASSERT(a_tick_starts_div, (req_valid && req_ready && !req_mode) |=> (state_ff == ST_DIV_CLK), "tick did not start the rate division")
   `WSG_ASSERT(a_done_in_div_state, stat.div_done |-> (state_ff == ST_DIV_CLK || state_ff == ST_DIV_NOISE || state_ff == ST_CH_DIV), "divider finished outside a wait state")
   `WSG_ASSERT(a_load_sets_valid, cmd.load_out |=> rsp_valid_ff, "loaded sample not offered")
   `WSG_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset did not return to idle")

endmodule

// ===== hw/rtl/six_channel_wavetable_sound_generator_core.sv =====
// ----------------------------------------------------------------------------
// six_channel_wavetable_sound_generator_core
// six-channel wavetable/noise/dda sound generator, one stereo word per tick
// ----------------------------------------------------------------------------
//   port    dir   handshake           word
//   req     in    valid/ready         mode, channel, field_select, wave_slot, write_value
//   rsp     out   valid/ready         left_sample, right_sample
//   csr     in    apb psel/penable    master_volume, channel_mask, sample_rate
//
// a field write is done on accept; a tick is accepted, then runs two rate divisions
// of a D-bit dividend (D = clock width + 16, 38 at the default clock) through one
// shared divider, then walks the six channels: each is loaded, then a wave channel
// takes a step division and a noise channel a phase add and one step per lfsr clock,
// then each is multiplied and accumulated; last the word goes to the output register
// reset is synchronous and clears all channel state, noise lfsrs to one, and the
// wave memory valid bits; the block takes requests only in idle, and a finished
// word waits in the output register while the next request is taken
// ----------------------------------------------------------------------------
module six_channel_wavetable_sound_generator_core
   import wsg_pkg::*;
#(
   parameter int PSG_CLOCK_HZ = 3579545
) (
   input  logic              clock,
   input  logic              reset,
   wsg_req_if.sink           req,
   wsg_rsp_if.source         rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   // configuration registers
   logic [7:0]        master_volume_ff;
   logic [NUM_CH-1:0] channel_mask_ff;
   logic [RATE_W-1:0] sample_rate_ff;
   logic              csr_wr;
   logic [1:0]        csr_idx;

   wsg_item_type item;
   wsg_cfg_type  cfg;
   wsg_cmd_type  cmd;
   wsg_stat_type stat;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   // registers sit on word addresses
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         master_volume_ff <= MASTER_VOLUME_RST;
         channel_mask_ff  <= CHANNEL_MASK_RST;
         sample_rate_ff   <= SAMPLE_RATE_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_MASTER_VOLUME: master_volume_ff <= pwdata[7:0];
            CSR_CHANNEL_MASK:  channel_mask_ff  <= pwdata[NUM_CH-1:0];
            CSR_SAMPLE_RATE:   sample_rate_ff   <= pwdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_MASTER_VOLUME: prdata = 32'(master_volume_ff);
         CSR_CHANNEL_MASK:  prdata = 32'(channel_mask_ff);
         CSR_SAMPLE_RATE:   prdata = 32'(sample_rate_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.master_volume = master_volume_ff;
   assign cfg.channel_mask  = channel_mask_ff;
   assign cfg.sample_rate   = sample_rate_ff;

   // request word straight from the port, used on the accept cycle only
   assign item.mode         = req.mode;
   assign item.channel      = req.channel;
   assign item.field_select = req.field_select;
   assign item.wave_slot    = req.wave_slot;
   assign item.write_value  = req.write_value;

   wsg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_mode  (req.mode),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   wsg_dp #(.PSG_CLOCK_HZ(PSG_CLOCK_HZ)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .item         (item),
      .cfg          (cfg),
      .left_sample  (rsp.left_sample),
      .right_sample (rsp.right_sample)
   );

endmodule
